FILE: hw/rtl/imhdk_pkg.sv
// ----------------------------------------------------------------------------
// imhdk_pkg
// Shared types and constants for the indexed min-heap with decrease-key.
// ----------------------------------------------------------------------------
package imhdk_pkg;

  localparam int NODES  = 1024;
  localparam int SLOT_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int KEY_W  = 32;
  localparam int NODE_W = 10;
  localparam int CFG_W  = 1;

  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_DECREASE = 2'd1;
  localparam logic [1:0] OP_EXTRACT  = 2'd2;

  localparam logic [CFG_W-1:0] CFG_ZERO_VALUE = 1'd0;
  localparam logic [CFG_W-1:0] CFG_MAX_VALUE  = 1'd1;

  typedef struct packed {
    logic [1:0]        op;
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } in_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] min_node;
    logic              found;
    logic [10:0]       count;
  } out_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
  } entry_t;

endpackage

FILE: hw/rtl/indexed_min_heap_decrease_key_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top
// Indexed binary min-heap of node ids keyed by 32-bit unsigned distance.
// ----------------------------------------------------------------------------
// After reset the block clears all NODES (1024) entries of its position
// table and takes no request meanwhile. It then handles one request at a time
// with a sequencer around simple dual-port heap and position memories;
// decrease-key climbs and extract-min descends the heap one level at a time,
// and each response may wait for the receiver. A node counts as present
// when its stored slot is below the heap size and that slot holds the node.
module indexed_min_heap_decrease_key_top
  import imhdk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output out_rsp_t         out_rsp,
  input  logic             cfg_en,
  input  logic [CFG_W-1:0] cfg_index,
  input  logic [KEY_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_DK_CHK, ST_DK_VER, ST_SU_RD, ST_SU_CMP, ST_EX_ROOT,
    ST_EX_LAST, ST_SD_L, ST_SD_LC, ST_SD_RC, ST_SD_MV, ST_FIN, ST_DONE
  } state_t;

  state_t            state;
  in_req_t           req;
  logic [KEY_W-1:0]  zero_value;
  logic [KEY_W-1:0]  max_value;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] s;
  logic [SLOT_W-1:0] clr;
  logic [SLOT_W-1:0] best_slot;
  entry_t            e;
  entry_t            best;
  logic              best_child;
  logic              hit;
  logic [NODE_W-1:0] min_node;
  logic              found;

  logic              heap_we;
  logic [SLOT_W-1:0] heap_waddr;
  entry_t            heap_wdata;
  logic [SLOT_W-1:0] heap_raddr;
  entry_t            heap_rdata;
  logic              pos_we;
  logic [SLOT_W-1:0] pos_waddr;
  logic [SLOT_W-1:0] pos_wdata;
  logic [SLOT_W-1:0] pos_raddr;
  logic [SLOT_W-1:0] pos_rdata;

  logic [SLOT_W-1:0] s_dec;
  logic [SLOT_W-1:0] parent;
  logic [CNT_W:0]    lft;
  logic [CNT_W:0]    rgt;
  logic [CNT_W-1:0]  last;
  logic              present;

  assign s_dec   = s - SLOT_W'(1);
  assign parent  = {1'b0, s_dec[SLOT_W-1:1]};
  assign lft     = {{(CNT_W - SLOT_W){1'b0}}, s, 1'b1};
  assign rgt     = lft + (CNT_W + 1)'(1);
  assign last    = count - CNT_W'(1);
  assign present = hit && (heap_rdata.node == req.node);
  assign in_ready = (state == ST_IDLE);

  imhdk_ram #(.WIDTH($bits(entry_t)), .DEPTH(NODES)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imhdk_ram #(.WIDTH(SLOT_W), .DEPTH(NODES)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = '0;
    heap_wdata = '0;
    heap_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = '0;
    pos_wdata  = '0;
    pos_raddr  = in_req.node[SLOT_W-1:0];
    case (state)
      ST_CLR: begin
        pos_we    = 1'b1;
        pos_waddr = clr;
      end
      ST_IDLE: begin
        if (in_valid && in_req.op == OP_START) begin
          heap_we    = 1'b1;
          heap_wdata = '{key: zero_value, node: in_req.node};
          pos_we     = 1'b1;
          pos_waddr  = in_req.node[SLOT_W-1:0];
        end
      end
      ST_DK_CHK: begin
        heap_raddr = pos_rdata;
      end
      ST_DK_VER: begin
        if (!present) begin
          heap_we    = 1'b1;
          heap_waddr = count[SLOT_W-1:0];
          heap_wdata = '{key: max_value, node: req.node};
        end
      end
      ST_SU_RD: begin
        heap_raddr = parent;
      end
      ST_SU_CMP: begin
        if (heap_rdata.key > e.key) begin
          heap_we    = 1'b1;
          heap_waddr = s;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata.node[SLOT_W-1:0];
          pos_wdata  = s;
        end
      end
      ST_EX_ROOT: begin
        heap_raddr = last[SLOT_W-1:0];
      end
      ST_SD_L: begin
        heap_raddr = lft[SLOT_W-1:0];
      end
      ST_SD_LC: begin
        heap_raddr = rgt[SLOT_W-1:0];
      end
      ST_SD_MV: begin
        if (best_child) begin
          heap_we    = 1'b1;
          heap_waddr = s;
          heap_wdata = best;
          pos_we     = 1'b1;
          pos_waddr  = best.node[SLOT_W-1:0];
          pos_wdata  = s;
        end
      end
      ST_FIN: begin
        heap_we    = 1'b1;
        heap_waddr = s;
        heap_wdata = e;
        pos_we     = 1'b1;
        pos_waddr  = e.node[SLOT_W-1:0];
        pos_wdata  = s;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr        <= '0;
      count      <= '0;
      zero_value <= '0;
      max_value  <= '1;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          CFG_ZERO_VALUE: zero_value <= cfg_data;
          CFG_MAX_VALUE:  max_value  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr <= clr + SLOT_W'(1);
          if (clr == SLOT_W'(NODES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req      <= in_req;
            min_node <= '0;
            found    <= 1'b0;
            case (in_req.op)
              OP_START: begin
                count <= CNT_W'(1);
                state <= ST_DONE;
              end
              OP_DECREASE: state <= ST_DK_CHK;
              OP_EXTRACT:  state <= (count == '0) ? ST_DONE : ST_EX_ROOT;
              default:     state <= ST_DONE;
            endcase
          end
        end
        ST_DK_CHK: begin
          hit   <= ({1'b0, pos_rdata} < count);
          s     <= pos_rdata;
          state <= ST_DK_VER;
        end
        ST_DK_VER: begin
          if (!present) begin
            s     <= count[SLOT_W-1:0];
            count <= count + CNT_W'(1);
          end
          e     <= '{key: req.key, node: req.node};
          state <= ST_SU_RD;
        end
        ST_SU_RD: begin
          state <= (s == '0) ? ST_FIN : ST_SU_CMP;
        end
        ST_SU_CMP: begin
          if (heap_rdata.key > e.key) begin
            s     <= parent;
            state <= ST_SU_RD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_EX_ROOT: begin
          min_node <= heap_rdata.node;
          found    <= 1'b1;
          if (count == CNT_W'(1)) begin
            count <= '0;
            state <= ST_DONE;
          end else begin
            state <= ST_EX_LAST;
          end
        end
        ST_EX_LAST: begin
          e     <= heap_rdata;
          count <= last;
          s     <= '0;
          state <= ST_SD_L;
        end
        ST_SD_L: begin
          state <= (lft < {1'b0, count}) ? ST_SD_LC : ST_FIN;
        end
        ST_SD_LC: begin
          if (heap_rdata.key < e.key) begin
            best       <= heap_rdata;
            best_child <= 1'b1;
            best_slot  <= lft[SLOT_W-1:0];
          end else begin
            best       <= e;
            best_child <= 1'b0;
          end
          state <= (rgt < {1'b0, count}) ? ST_SD_RC : ST_SD_MV;
        end
        ST_SD_RC: begin
          if (heap_rdata.key < best.key) begin
            best       <= heap_rdata;
            best_child <= 1'b1;
            best_slot  <= rgt[SLOT_W-1:0];
          end
          state <= ST_SD_MV;
        end
        ST_SD_MV: begin
          if (best_child) begin
            s     <= best_slot;
            state <= ST_SD_L;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_rsp   <= '{min_node: min_node, found: found, count: 11'(count)};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NODES))
    else $error("heap size above capacity");

  a_sift_up_slot: assert property (@(posedge clk) disable iff (rst)
    state == ST_SU_RD |-> {1'b0, s} < count)
    else $error("sift-up slot outside heap");

  a_sift_down_slot: assert property (@(posedge clk) disable iff (rst)
    state == ST_SD_L |-> {1'b0, s} < count)
    else $error("sift-down slot outside heap");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.found |-> out_rsp.min_node == '0)
    else $error("min node set without a removal");

endmodule

FILE: hw/rtl/imhdk_ram.sv
// ----------------------------------------------------------------------------
// imhdk_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module imhdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
